[rtl/sr2k_pkg.sv]
// shared types, codes and the fixed-point saturation helper for the rank-2k update
`default_nettype none
package sr2k_pkg;

    // element and accumulator widths
    localparam int DATA_W = 32;
    localparam int PROD_W = 64;
    localparam int ACC_W  = 68;
    localparam int SHR_W  = ACC_W - 16;

    // request opcodes
    localparam logic [1:0] OP_LOAD_A = 2'd0;
    localparam logic [1:0] OP_LOAD_B = 2'd1;
    localparam logic [1:0] OP_LOAD_C = 2'd2;
    localparam logic [1:0] OP_START  = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_ORDER = 3'd0;
    localparam logic [2:0] REG_INNER = 3'd1;
    localparam logic [2:0] REG_UPPER = 3'd2;
    localparam logic [2:0] REG_TRANS = 3'd3;
    localparam logic [2:0] REG_ALPHA = 3'd4;
    localparam logic [2:0] REG_BETA  = 3'd5;

    // multiplier operand select
    localparam logic [1:0] MUL_AB    = 2'd0;
    localparam logic [1:0] MUL_BETA  = 2'd1;
    localparam logic [1:0] MUL_ALPHA = 2'd2;

    // accumulator operation
    localparam logic [1:0] ACC_HOLD  = 2'd0;
    localparam logic [1:0] ACC_CLEAR = 2'd1;
    localparam logic [1:0] ACC_LOAD  = 2'd2;
    localparam logic [1:0] ACC_ADD   = 2'd3;

    typedef struct packed {
        logic [1:0] mul_sel;
        logic [1:0] acc_op;
        logic       sv_load;
    } t_dp_ctl;

    // floor by 16 bits, then saturate to signed 32 bits
    function automatic logic [DATA_W-1:0] sat_q16(input logic [ACC_W-1:0] v);
        logic [SHR_W-1:0] t;
        logic [SHR_W-1:DATA_W-1] hi;
        t  = v[ACC_W-1:16];
        hi = t[SHR_W-1:DATA_W-1];
        if ((&hi) || (~|hi)) begin
            sat_q16 = t[DATA_W-1:0];
        end else if (t[SHR_W-1]) begin
            sat_q16 = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            sat_q16 = {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

endpackage
`default_nettype wire

[rtl/sr2k_in_if.sv]
// request channel: load and start items
`default_nettype none
interface sr2k_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [2:0]         row_index;
    logic [2:0]         col_index;
    logic signed [31:0] element_value;

    modport source (output valid, opcode, row_index, col_index, element_value, input ready);
    modport sink   (input valid, opcode, row_index, col_index, element_value, output ready);
endinterface
`default_nettype wire

[rtl/sr2k_out_if.sv]
// result channel: updated triangle entries of C
`default_nettype none
interface sr2k_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic signed [31:0] out_value;
    logic               last_entry;

    modport source (output valid, out_row, out_col, out_value, last_entry, input ready);
    modport sink   (input valid, out_row, out_col, out_value, last_entry, output ready);
endinterface
`default_nettype wire

[rtl/sr2k_dp.sv]
// shared multiplier, wide accumulator and saturation for the rank-2k update
`default_nettype none
module sr2k_dp (
    input  wire logic                           i_clk,
    input  wire sr2k_pkg::t_dp_ctl              i_ctl,
    input  wire logic [sr2k_pkg::DATA_W-1:0]    i_a,
    input  wire logic [sr2k_pkg::DATA_W-1:0]    i_b,
    input  wire logic [sr2k_pkg::DATA_W-1:0]    i_c,
    input  wire logic [sr2k_pkg::DATA_W-1:0]    i_alpha,
    input  wire logic [sr2k_pkg::DATA_W-1:0]    i_beta,
    output logic [sr2k_pkg::DATA_W-1:0]         o_result
);

    logic signed [sr2k_pkg::DATA_W-1:0] mul_x;
    logic signed [sr2k_pkg::DATA_W-1:0] mul_y;
    logic signed [sr2k_pkg::PROD_W-1:0] r_prod;
    logic [sr2k_pkg::ACC_W-1:0]         r_acc;
    logic [sr2k_pkg::ACC_W-1:0]         prod_ext;
    logic [sr2k_pkg::DATA_W-1:0]        r_sv;

    // operand select for the one multiplier
    always_comb begin
        case (i_ctl.mul_sel)
            sr2k_pkg::MUL_BETA: begin
                mul_x = i_beta;
                mul_y = i_c;
            end
            sr2k_pkg::MUL_ALPHA: begin
                mul_x = i_alpha;
                mul_y = r_sv;
            end
            default: begin
                mul_x = i_a;
                mul_y = i_b;
            end
        endcase
    end

    assign prod_ext = {{(sr2k_pkg::ACC_W-sr2k_pkg::PROD_W){r_prod[sr2k_pkg::PROD_W-1]}}, r_prod};

    // product register, then accumulate
    always_ff @(posedge i_clk) begin
        r_prod <= mul_x * mul_y;
        case (i_ctl.acc_op)
            sr2k_pkg::ACC_CLEAR: r_acc <= '0;
            sr2k_pkg::ACC_LOAD:  r_acc <= prod_ext;
            sr2k_pkg::ACC_ADD:   r_acc <= r_acc + prod_ext;
            default:             r_acc <= r_acc;
        endcase
        if (i_ctl.sv_load) begin
            r_sv <= sr2k_pkg::sat_q16(r_acc);
        end
    end

    assign o_result = sr2k_pkg::sat_q16(r_acc);

endmodule
`default_nettype wire

[rtl/symmetric_rank2k_update.sv]
// top level: element stores, entry sequencer and result register of the rank-2k update
// loads are accepted back to back while the sequencer is idle
// a start walks n(n+1)/2 entries; each product term passes store read, multiply and
// accumulate through the shared multiplier, then comes the alpha/beta update; output
// back-pressure adds stall cycles at the result register
// reset (synchronous, active low) clears the sequencer, configuration and result valid; stores are not cleared
`default_nettype none
module symmetric_rank2k_update #(
    parameter int MAX_N = 8,
    parameter int MAX_K = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    sr2k_in_if.sink         i_req,
    sr2k_out_if.source      o_res,
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    localparam logic [3:0] NCAP = 4'((MAX_N < 8) ? MAX_N : 8);
    localparam logic [3:0] KCAP = 4'((MAX_K < 8) ? MAX_K : 8);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_SV   = 3'd4;
    localparam logic [2:0] S_FA   = 3'd5;
    localparam logic [2:0] S_FS   = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    // configuration registers
    logic [3:0]  r_order;
    logic [3:0]  r_inner;
    logic        r_upper;
    logic        r_trans;
    logic [31:0] r_alpha;
    logic [31:0] r_beta;

    // sequencer state
    logic [2:0] r_state, n_state;
    logic [3:0] r_n, n_n;
    logic [3:0] r_k, n_k;
    logic [2:0] r_i, n_i;
    logic [2:0] r_j, n_j;
    logic [2:0] r_l, n_l;
    logic       r_ph, n_ph;

    // result register
    logic        r_ov;
    logic [2:0]  r_orow;
    logic [2:0]  r_ocol;
    logic [31:0] r_oval;
    logic        r_olast;

    // stores
    logic [31:0] mem_a [64];
    logic [31:0] mem_b [64];
    logic [31:0] mem_c [64];
    logic [31:0] r_a_q;
    logic [31:0] r_b_q;
    logic [31:0] r_c_q;

    logic                req_fire;
    logic                out_free;
    logic                ld_out;
    logic                entry_end;
    logic                run_end;
    logic [2:0]          ax;
    logic [2:0]          bx;
    logic [5:0]          a_raddr;
    logic [5:0]          b_raddr;
    logic [5:0]          c_raddr;
    logic [5:0]          ld_addr;
    logic [5:0]          c_waddr;
    logic [31:0]         c_wdata;
    logic                c_we;
    logic [31:0]         result;
    sr2k_pkg::t_dp_ctl   dp_ctl;

    assign req_fire  = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign out_free  = !r_ov || o_res.ready;
    assign ld_out    = (r_state == S_OUT) && out_free;
    assign entry_end = r_upper ? (r_i == r_j) : ({1'b0, r_i} == r_n - 4'd1);
    assign run_end   = entry_end && ({1'b0, r_j} == r_n - 4'd1);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= '0;
            r_inner <= '0;
            r_upper <= 1'b1;
            r_trans <= 1'b0;
            r_alpha <= 32'h0001_0000;
            r_beta  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sr2k_pkg::REG_ORDER: r_order <= i_cfg_data[3:0];
                sr2k_pkg::REG_INNER: r_inner <= i_cfg_data[3:0];
                sr2k_pkg::REG_UPPER: r_upper <= i_cfg_data[0];
                sr2k_pkg::REG_TRANS: r_trans <= i_cfg_data[0];
                sr2k_pkg::REG_ALPHA: r_alpha <= i_cfg_data;
                sr2k_pkg::REG_BETA:  r_beta  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // store addresses: phase 0 reads A(x=i) and B(x=j), phase 1 swaps the roles
    assign ax      = r_ph ? r_j : r_i;
    assign bx      = r_ph ? r_i : r_j;
    assign a_raddr = r_trans ? {r_l, ax} : {ax, r_l};
    assign b_raddr = r_trans ? {r_l, bx} : {bx, r_l};
    assign c_raddr = {r_i, r_j};
    assign ld_addr = {i_req.row_index, i_req.col_index};
    assign c_we    = ld_out || (req_fire && i_req.opcode == sr2k_pkg::OP_LOAD_C);
    assign c_waddr = ld_out ? {r_i, r_j} : ld_addr;
    assign c_wdata = ld_out ? result : i_req.element_value;

    // element stores with registered reads
    always_ff @(posedge i_clk) begin
        if (req_fire && i_req.opcode == sr2k_pkg::OP_LOAD_A) begin
            mem_a[ld_addr] <= i_req.element_value;
        end
        if (req_fire && i_req.opcode == sr2k_pkg::OP_LOAD_B) begin
            mem_b[ld_addr] <= i_req.element_value;
        end
        if (c_we) begin
            mem_c[c_waddr] <= c_wdata;
        end
        r_a_q <= mem_a[a_raddr];
        r_b_q <= mem_b[b_raddr];
        r_c_q <= mem_c[c_raddr];
    end

    // sequencer next state and datapath control
    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_k     = r_k;
        n_i     = r_i;
        n_j     = r_j;
        n_l     = r_l;
        n_ph    = r_ph;
        dp_ctl  = '{mul_sel: sr2k_pkg::MUL_AB, acc_op: sr2k_pkg::ACC_HOLD, sv_load: 1'b0};
        case (r_state)
            S_IDLE: begin
                if (req_fire && i_req.opcode == sr2k_pkg::OP_START) begin
                    n_n  = (r_order > NCAP) ? NCAP : r_order;
                    n_k  = (r_inner > KCAP) ? KCAP : r_inner;
                    n_i  = '0;
                    n_j  = '0;
                    n_l  = '0;
                    n_ph = 1'b0;
                    if (n_n != 4'd0) begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                if (r_l == 3'd0 && !r_ph) begin
                    dp_ctl.acc_op = sr2k_pkg::ACC_CLEAR;
                end
                n_state = (r_k == 4'd0) ? S_SV : S_MUL;
            end
            S_MUL: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                dp_ctl.acc_op = sr2k_pkg::ACC_ADD;
                if (!r_ph) begin
                    n_ph    = 1'b1;
                    n_state = S_RD;
                end else if ({1'b0, r_l} == r_k - 4'd1) begin
                    n_state = S_SV;
                end else begin
                    n_l     = r_l + 3'd1;
                    n_ph    = 1'b0;
                    n_state = S_RD;
                end
            end
            S_SV: begin
                dp_ctl.sv_load = 1'b1;
                dp_ctl.mul_sel = sr2k_pkg::MUL_BETA;
                n_state        = S_FA;
            end
            S_FA: begin
                dp_ctl.acc_op  = sr2k_pkg::ACC_LOAD;
                dp_ctl.mul_sel = sr2k_pkg::MUL_ALPHA;
                n_state        = S_FS;
            end
            S_FS: begin
                dp_ctl.acc_op = sr2k_pkg::ACC_ADD;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_l  = '0;
                    n_ph = 1'b0;
                    if (run_end) begin
                        n_state = S_IDLE;
                    end else if (entry_end) begin
                        n_j     = r_j + 3'd1;
                        n_i     = r_upper ? 3'd0 : r_j + 3'd1;
                        n_state = S_RD;
                    end else begin
                        n_i     = r_i + 3'd1;
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n     <= '0;
            r_k     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_l     <= '0;
            r_ph    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_k     <= n_k;
            r_i     <= n_i;
            r_j     <= n_j;
            r_l     <= n_l;
            r_ph    <= n_ph;
        end
    end

    // shared arithmetic
    sr2k_dp u_dp (
        .i_clk    (i_clk),
        .i_ctl    (dp_ctl),
        .i_a      (r_a_q),
        .i_b      (r_b_q),
        .i_c      (r_c_q),
        .i_alpha  (r_alpha),
        .i_beta   (r_beta),
        .o_result (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (ld_out) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            r_orow  <= r_i;
            r_ocol  <= r_j;
            r_oval  <= result;
            r_olast <= run_end;
        end
    end

    assign o_res.valid      = r_ov;
    assign o_res.out_row    = r_orow;
    assign o_res.out_col    = r_ocol;
    assign o_res.out_value  = r_oval;
    assign o_res.last_entry = r_olast;

`ifndef SYNTHESIS
    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_ov && !o_res.ready) |=> (r_state == S_OUT))
        else $error("result register overwritten");

    // the final entry of a run returns the sequencer to idle
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld_out && run_end) |=> (r_state == S_IDLE))
        else $error("run did not end after last entry");

    // column counter stays inside the order while running
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> ({1'b0, r_j} < r_n))
        else $error("column counter out of range");

    // emitted entries lie in the selected triangle
    a_triangle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && r_state != S_IDLE) |->
            (r_upper ? (o_res.out_row <= o_res.out_col) : (o_res.out_row >= o_res.out_col)))
        else $error("entry outside triangle");
`endif

endmodule
`default_nettype wire

[dv/symmetric_rank2k_update_tb.sv]
// self-checking testbench for the symmetric rank-2k update with its own triangle predictor
`default_nettype none
module symmetric_rank2k_update_tb;

    localparam int ITEMS       = 310;
    localparam int IDLE_STOP   = 250;
    localparam int SETTLE      = 64;
    localparam int QUIET_LIMIT = 4000;

    // keeps a copy of the stores and registers, predicts every emitted C entry
    class rank2k_ledger;
        typedef logic signed [79:0] wide_t;
        typedef struct packed {
            logic [2:0]         row;
            logic [2:0]         col;
            logic signed [31:0] value;
            logic               last;
        } entry_t;

        logic signed [31:0] a_mem[64];
        logic signed [31:0] b_mem[64];
        logic signed [31:0] c_mem[64];
        bit                 loaded[3][64];
        logic [3:0]         order_reg;
        logic [3:0]         inner_reg;
        logic               upper_reg;
        logic               trans_reg;
        logic signed [31:0] alpha_reg;
        logic signed [31:0] beta_reg;
        entry_t             pending_entries[$];
        int                 n_checked;
        int                 n_errors;

        function new();
            order_reg = 4'd0;
            inner_reg = 4'd0;
            upper_reg = 1'b1;
            trans_reg = 1'b0;
            alpha_reg = 32'sh0001_0000;
            beta_reg  = 32'sh0000_0000;
            n_checked = 0;
            n_errors  = 0;
        endfunction

        function void note_mismatch(string msg);
            n_errors++;
            if (n_errors <= 10) $display("mismatch: %s", msg);
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                sr2k_pkg::REG_ORDER: order_reg = data[3:0];
                sr2k_pkg::REG_INNER: inner_reg = data[3:0];
                sr2k_pkg::REG_UPPER: upper_reg = data[0];
                sr2k_pkg::REG_TRANS: trans_reg = data[0];
                sr2k_pkg::REG_ALPHA: alpha_reg = data;
                sr2k_pkg::REG_BETA:  beta_reg  = data;
                default: ;
            endcase
        endfunction

        // exact signed product of two Q16.16 values
        function wide_t full_product(logic signed [31:0] x, logic signed [31:0] y);
            wide_t wx;
            wide_t wy;
            wx = x;
            wy = y;
            return wx * wy;
        endfunction

        // drop 16 fraction bits toward minus infinity, clamp to 32 bits
        function logic signed [31:0] floor_clamp(wide_t v);
            wide_t t;
            t = v >>> 16;
            if (t[79:31] == {49{t[79]}}) return $signed(t[31:0]);
            if (t[79]) return 32'sh8000_0000;
            return 32'sh7fff_ffff;
        endfunction

        // walk the selected triangle column by column and queue each updated entry
        function void compute_triangle();
            int n, k, total, count, i, j, l, lo_i, hi_i;
            wide_t acc;
            logic signed [31:0] sum_q, new_c;
            entry_t e;
            n = (order_reg > 8) ? 8 : int'(order_reg);
            k = (inner_reg > 8) ? 8 : int'(inner_reg);
            total = n * (n + 1) / 2;
            count = 0;
            for (j = 0; j < n; j++) begin
                lo_i = upper_reg ? 0 : j;
                hi_i = upper_reg ? j : n - 1;
                for (i = lo_i; i <= hi_i; i++) begin
                    acc = '0;
                    for (l = 0; l < k; l++) begin
                        if (trans_reg) begin
                            acc += full_product(a_mem[l*8+i], b_mem[l*8+j])
                                 + full_product(b_mem[l*8+i], a_mem[l*8+j]);
                        end else begin
                            acc += full_product(a_mem[i*8+l], b_mem[j*8+l])
                                 + full_product(b_mem[i*8+l], a_mem[j*8+l]);
                        end
                    end
                    sum_q = floor_clamp(acc);
                    new_c = floor_clamp(full_product(beta_reg, c_mem[i*8+j])
                                        + full_product(alpha_reg, sum_q));
                    c_mem[i*8+j] = new_c;
                    count++;
                    e.row   = i[2:0];
                    e.col   = j[2:0];
                    e.value = new_c;
                    e.last  = (count == total);
                    pending_entries.push_back(e);
                end
            end
        endfunction

        function void note_request(logic [1:0] op, logic [2:0] row, logic [2:0] col,
                                   logic signed [31:0] val);
            case (op)
                sr2k_pkg::OP_LOAD_A: a_mem[{row, col}] = val;
                sr2k_pkg::OP_LOAD_B: b_mem[{row, col}] = val;
                sr2k_pkg::OP_LOAD_C: c_mem[{row, col}] = val;
                sr2k_pkg::OP_START:  compute_triangle();
                default: ;
            endcase
            if (op != sr2k_pkg::OP_START) loaded[op][{row, col}] = 1'b1;
        endfunction

        function void check_entry(logic [2:0] row, logic [2:0] col,
                                  logic signed [31:0] value, logic last);
            entry_t e;
            n_checked++;
            if (pending_entries.size() == 0) begin
                note_mismatch($sformatf("unexpected entry (%0d,%0d) %0d last %0b",
                                        row, col, value, last));
                return;
            end
            e = pending_entries.pop_front();
            if (e.row !== row || e.col !== col || e.value !== value || e.last !== last) begin
                note_mismatch($sformatf("expected (%0d,%0d) %0d last %0b, got (%0d,%0d) %0d last %0b",
                                        e.row, e.col, e.value, e.last, row, col, value, last));
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    sr2k_in_if  req_if ();
    sr2k_out_if res_if ();

    symmetric_rank2k_update dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    rank2k_ledger ledger;
    bit           gaps_on;
    int           n_requests;
    int           n_starts;
    int           n_settings;
    int           stall_left;
    int           quiet_cycles;
    logic [1:0]   load_ops[3] = '{sr2k_pkg::OP_LOAD_A, sr2k_pkg::OP_LOAD_B, sr2k_pkg::OP_LOAD_C};

    // clock
    always #5 i_clk = ~i_clk;

    function automatic bit gaps_allowed();
        return gaps_on && (n_requests < IDLE_STOP);
    endfunction

    function automatic logic signed [31:0] rand_element();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0: v = 32'sh7fff_ffff;
            1: v = 32'sh8000_0000;
            2, 3: v = $urandom;
            default: begin
                v = $urandom_range(0, 262143);
                v = v - 32'sd131072;
            end
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] rand_gain();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0: v = 32'sh0000_0000;
            1: v = 32'sh0001_0000;
            2: v = -32'sh0001_0000;
            3: v = 32'sh7fff_ffff;
            4: v = 32'sh8000_0000;
            5: v = $urandom;
            default: begin
                v = $urandom_range(0, 524287);
                v = v - 32'sd262144;
            end
        endcase
        return v;
    endfunction

    // one request, with an optional idle burst in front of it
    task automatic send_request(input logic [1:0] op, input logic [2:0] row,
                                input logic [2:0] col, input logic signed [31:0] val);
        int gap;
        if (gaps_allowed() && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            @(negedge i_clk);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_if.valid         <= 1'b1;
        req_if.opcode        <= op;
        req_if.row_index     <= row;
        req_if.col_index     <= col;
        req_if.element_value <= val;
        do @(posedge i_clk); while (!req_if.ready);
        ledger.note_request(op, row, col, val);
        n_requests++;
        if (op == sr2k_pkg::OP_START) n_starts++;
    endtask

    // lower valid right after the last accepted request, then wait for the block to go quiet
    task automatic drain();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (ledger.pending_entries.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        ledger.set_reg(idx, data);
    endtask

    task automatic configure(input logic [3:0] order, input logic [3:0] inner,
                             input logic upper, input logic trans,
                             input logic signed [31:0] alpha, input logic signed [31:0] beta);
        drain();
        write_reg(sr2k_pkg::REG_ORDER, {28'd0, order});
        write_reg(sr2k_pkg::REG_INNER, {28'd0, inner});
        write_reg(sr2k_pkg::REG_UPPER, {31'd0, upper});
        write_reg(sr2k_pkg::REG_TRANS, {31'd0, trans});
        write_reg(sr2k_pkg::REG_ALPHA, alpha);
        write_reg(sr2k_pkg::REG_BETA, beta);
        n_settings++;
    endtask

    // load whatever the next run would read that was never written, then start
    task automatic start_run();
        int n, k, rows, cols, r, c, m;
        n = (ledger.order_reg > 8) ? 8 : int'(ledger.order_reg);
        k = (ledger.inner_reg > 8) ? 8 : int'(ledger.inner_reg);
        rows = ledger.trans_reg ? k : n;
        cols = ledger.trans_reg ? n : k;
        for (m = 0; m < 2; m++) begin
            for (r = 0; r < rows; r++) begin
                for (c = 0; c < cols; c++) begin
                    if (!ledger.loaded[load_ops[m]][r*8+c])
                        send_request(load_ops[m], r[2:0], c[2:0], rand_element());
                end
            end
        end
        for (c = 0; c < n; c++) begin
            for (r = 0; r < n; r++) begin
                if ((ledger.upper_reg ? r <= c : r >= c) &&
                    !ledger.loaded[sr2k_pkg::OP_LOAD_C][r*8+c])
                    send_request(sr2k_pkg::OP_LOAD_C, r[2:0], c[2:0], rand_element());
            end
        end
        send_request(sr2k_pkg::OP_START, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                     $urandom);
    endtask

    // result side ready with random stall bursts
    always @(negedge i_clk) begin
        if (!gaps_allowed()) begin
            res_if.ready <= 1'b1;
        end else if (stall_left > 0) begin
            res_if.ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            res_if.ready <= 1'b0;
            stall_left = $urandom_range(1, 9) - 1;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // result check and watchdog on handshake activity
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            ledger.check_entry(res_if.out_row, res_if.out_col, res_if.out_value,
                               res_if.last_entry);
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : main_flow
        logic [3:0] order;
        logic [3:0] inner;
        int         set_no;
        ledger       = new();
        gaps_on      = 1'b1;
        n_requests   = 0;
        n_starts     = 0;
        n_settings   = 0;
        stall_left   = 0;
        quiet_cycles = 0;
        set_no       = 0;
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = sr2k_pkg::REG_ORDER;
        i_cfg_data           = 32'd0;
        req_if.valid         = 1'b0;
        req_if.opcode        = sr2k_pkg::OP_LOAD_A;
        req_if.row_index     = 3'd0;
        req_if.col_index     = 3'd0;
        req_if.element_value = 32'sd0;
        res_if.ready         = 1'b0;

        // reset
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: single entry with extreme gains and elements, run twice, saturating toward the negative limit
        configure(4'd1, 4'd1, 1'b1, 1'b0, 32'sh7fff_ffff, 32'sh8000_0000);
        send_request(sr2k_pkg::OP_LOAD_A, 3'd0, 3'd0, 32'sh7fff_ffff);
        send_request(sr2k_pkg::OP_LOAD_B, 3'd0, 3'd0, 32'sh8000_0000);
        send_request(sr2k_pkg::OP_LOAD_C, 3'd0, 3'd0, 32'sh7fff_ffff);
        send_request(sr2k_pkg::OP_LOAD_A, 3'd7, 3'd7, 32'sh8000_0000);
        send_request(sr2k_pkg::OP_LOAD_B, 3'd7, 3'd7, 32'sh7fff_ffff);
        send_request(sr2k_pkg::OP_LOAD_C, 3'd7, 3'd0, -32'sd1);
        start_run();
        start_run();

        // directed: zero order gives no entries
        configure(4'd0, 4'd3, 1'b0, 1'b1, 32'sh0001_0000, 32'sh0001_0000);
        start_run();

        // directed: zero inner size, lower triangle, beta one and alpha zero
        configure(4'd2, 4'd0, 1'b0, 1'b0, 32'sh0000_0000, 32'sh0001_0000);
        start_run();

        // directed: transposed upper triangle with negative alpha
        configure(4'd2, 4'd1, 1'b1, 1'b1, -32'sh0001_0000, 32'sh0000_0000);
        start_run();

        // random settings, each with a few rounds of loads followed by a start
        while (n_requests < ITEMS) begin
            if (set_no == 1) begin
                configure(4'd15, 4'd15, 1'b0, 1'b1, rand_gain(), rand_gain());
            end else if (set_no == 3) begin
                configure(4'd8, 4'd8, 1'b1, 1'b0, rand_gain(), rand_gain());
            end else begin
                case ($urandom_range(0, 9))
                    0: order = 4'($urandom_range(9, 15));
                    1: order = 4'd8;
                    2: order = 4'd0;
                    default: order = 4'($urandom_range(1, 4));
                endcase
                case ($urandom_range(0, 9))
                    0: inner = 4'($urandom_range(9, 15));
                    1: inner = 4'd8;
                    2: inner = 4'd0;
                    default: inner = 4'($urandom_range(1, 4));
                endcase
                configure(order, inner, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          rand_gain(), rand_gain());
            end
            gaps_on = ($urandom_range(0, 3) != 0);
            set_no++;
            repeat ($urandom_range(1, 3)) begin
                repeat ($urandom_range(0, 6))
                    send_request(load_ops[$urandom_range(0, 2)], 3'($urandom_range(0, 7)),
                                 3'($urandom_range(0, 7)), rand_element());
                start_run();
            end
        end

        // wrap up
        drain();
        if (ledger.pending_entries.size() != 0)
            ledger.note_mismatch($sformatf("%0d entries never arrived",
                                           ledger.pending_entries.size()));
        $display("covered %0d requests with %0d starts over %0d register settings",
                 n_requests, n_starts, n_settings);
        $display("checked %0d triangle entries, %0d mismatches", ledger.n_checked,
                 ledger.n_errors);
        if (ledger.n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
